[rtl/core/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared constants, command/status types for the SHA-1 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

  // initial chaining values
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;  // fill level where the length goes
  localparam logic [5:0] LAST_FILL  = 6'd63;  // push at this fill completes a block
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] RND_PAR1   = 7'd20;
  localparam logic [6:0] RND_MAJ    = 7'd40;
  localparam logic [6:0] RND_PAR2   = 7'd60;
  localparam logic [2:0] LAST_WORD  = 3'd4;
  localparam logic [2:0] LAST_LEN   = 3'd7;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef enum logic [1:0] {
    FN_CH,
    FN_PAR1,
    FN_MAJ,
    FN_PAR2
  } rnd_fn_t;

  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic [2:0] len_idx;
    logic      count_inc;
    logic      load_work;
    logic      round;
    rnd_fn_t   rnd_fn;
    logic      add_chain;
    logic      restart;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/sha1_datapath.sv]
// ----------------------------------------------------------------------------
// sha1_datapath
// Block buffer / rolling schedule, working variables, chain and length count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sha1_pkg::cmd_t cmd,
  input  wire logic [7:0]    data_byte,
  output sha1_pkg::sts_t     sts,
  output logic [31:0]        digest_word
);

  logic [4:0][31:0] chain_r;
  logic [63:0]      cnt_r;
  logic [5:0]       fill_r;
  logic [511:0]     blk_r;   // word 0 (oldest) in the top bits
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;

  logic [63:0] bitlen;
  logic [5:0]  len_pos;
  logic [7:0]  push_byte;
  logic [31:0] w0, w2, w8, w13, wx, wnew;
  logic [31:0] f, k, t;

  always_comb begin
    bitlen  = {cnt_r[60:0], 3'b000};
    len_pos = {sha1_pkg::LAST_LEN - cmd.len_idx, 3'b000};
    case (cmd.byte_sel)
      sha1_pkg::SEL_DATA: push_byte = data_byte;
      sha1_pkg::SEL_PAD:  push_byte = sha1_pkg::PAD_BYTE;
      sha1_pkg::SEL_LEN:  push_byte = bitlen[len_pos +: 8];
      default:            push_byte = 8'h00;
    endcase

    w0   = blk_r[511:480];
    w2   = blk_r[447:416];
    w8   = blk_r[255:224];
    w13  = blk_r[95:64];
    wx   = w13 ^ w8 ^ w2 ^ w0;
    wnew = {wx[30:0], wx[31]};

    case (cmd.rnd_fn)
      sha1_pkg::FN_CH: begin
        f = (b_r & c_r) | (~b_r & d_r);
        k = sha1_pkg::K0;
      end
      sha1_pkg::FN_PAR1: begin
        f = b_r ^ c_r ^ d_r;
        k = sha1_pkg::K1;
      end
      sha1_pkg::FN_MAJ: begin
        f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k = sha1_pkg::K2;
      end
      default: begin
        f = b_r ^ c_r ^ d_r;
        k = sha1_pkg::K3;
      end
    endcase
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w0;
  end

  // buffer doubles as the 16-word schedule window during compression
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r <= {blk_r[503:0], push_byte};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], wnew};
    end
    if (cmd.load_work) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      chain_r <= {sha1_pkg::H4, sha1_pkg::H3, sha1_pkg::H2, sha1_pkg::H1, sha1_pkg::H0};
      cnt_r   <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd.add_chain) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.count_inc) begin
        cnt_r <= cnt_r + 64'd1;
      end
      if (cmd.push) begin
        fill_r <= fill_r + 6'd1;  // wraps to 0 when a block completes
      end
    end
  end

  always_comb begin
    case (cmd.out_idx)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      default: digest_word = chain_r[4];
    endcase
  end

  assign sts.fill = fill_r;

endmodule

`default_nettype wire

[rtl/core/sha1_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, padding, 80-round compression, digest readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          in_tlast,
  input  wire logic          in_end_only,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic               out_tlast,
  output logic [2:0]         out_idx,
  input  wire sha1_pkg::sts_t sts,
  output sha1_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FINAL,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    P_80,
    P_ZERO,
    P_LEN
  } phase_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] len_idx_r, len_idx_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       ending_r, ending_nxt;
  logic       done_r, done_nxt;

  logic in_acc, msg_end, full;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    rnd_nxt     = rnd_r;
    len_idx_nxt = len_idx_r;
    widx_nxt    = widx_r;
    ending_nxt  = ending_r;
    done_nxt    = done_r;

    cmd           = '0;
    cmd.byte_sel  = sha1_pkg::SEL_DATA;
    cmd.rnd_fn    = sha1_pkg::FN_CH;
    cmd.len_idx   = len_idx_r;
    cmd.out_idx   = widx_r;

    in_acc  = in_tvalid && (state_r == S_IDLE);
    msg_end = in_tlast || in_end_only;
    full    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.push      = !in_end_only;
          cmd.count_inc = !in_end_only;
          full          = !in_end_only && (sts.fill == sha1_pkg::LAST_FILL);
          ending_nxt    = msg_end;
          phase_nxt     = P_80;
          if (full) begin
            cmd.load_work = 1'b1;
            state_nxt     = S_COMP;
          end else if (msg_end) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        full     = (sts.fill == sha1_pkg::LAST_FILL);
        case (phase_r)
          P_80: begin
            cmd.byte_sel = sha1_pkg::SEL_PAD;
            phase_nxt    = P_ZERO;
          end
          P_ZERO: begin
            if (sts.fill == sha1_pkg::LEN_START) begin
              cmd.byte_sel = sha1_pkg::SEL_LEN;
              len_idx_nxt  = len_idx_r + 3'd1;
              phase_nxt    = P_LEN;
            end else begin
              cmd.byte_sel = sha1_pkg::SEL_ZERO;
            end
          end
          default: begin
            cmd.byte_sel = sha1_pkg::SEL_LEN;
            len_idx_nxt  = len_idx_r + 3'd1;
            if (len_idx_r == sha1_pkg::LAST_LEN) begin
              done_nxt = 1'b1;
            end
          end
        endcase
        if (full) begin
          cmd.load_work = 1'b1;
          state_nxt     = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        if (rnd_r < sha1_pkg::RND_PAR1) begin
          cmd.rnd_fn = sha1_pkg::FN_CH;
        end else if (rnd_r < sha1_pkg::RND_MAJ) begin
          cmd.rnd_fn = sha1_pkg::FN_PAR1;
        end else if (rnd_r < sha1_pkg::RND_PAR2) begin
          cmd.rnd_fn = sha1_pkg::FN_MAJ;
        end else begin
          cmd.rnd_fn = sha1_pkg::FN_PAR2;
        end
        if (rnd_r == sha1_pkg::LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = S_FINAL;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      S_FINAL: begin
        cmd.add_chain = 1'b1;
        widx_nxt      = '0;
        if (done_r) begin
          state_nxt = S_OUT;
        end else if (ending_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (widx_r == sha1_pkg::LAST_WORD) begin
            cmd.restart = 1'b1;
            ending_nxt  = 1'b0;
            done_nxt    = 1'b0;
            len_idx_nxt = '0;
            phase_nxt   = P_80;
            state_nxt   = S_IDLE;
          end else begin
            widx_nxt = widx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= P_80;
      rnd_r     <= '0;
      len_idx_r <= '0;
      widx_r    <= '0;
      ending_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      rnd_r     <= rnd_nxt;
      len_idx_r <= len_idx_nxt;
      widx_r    <= widx_nxt;
      ending_r  <= ending_nxt;
      done_r    <= done_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = (widx_r == sha1_pkg::LAST_WORD);
  assign out_idx    = widx_r;

endmodule

`default_nettype wire

[rtl/core/sha1_hash_engine.sv]
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 digest of a byte stream, one byte per input word.
// ----------------------------------------------------------------------------
// Input stream: in_tdata carries one message byte, in_tlast marks the last
// byte, in_tuser[0] (end only) closes the message without a byte, so an
// empty message is allowed.
// Output stream: five words per message, H0 first; out_tuser gives the word
// index and out_tlast flags the fifth word.
// Throughput: one byte per cycle while a block fills. The byte that
// completes a 64-byte block starts the 80 rounds of the single round unit
// and one chain update before in_tready returns.
// Message end: padding and length go in one byte per cycle, with one or two
// block compressions, then the digest words.
// Reset: synchronous, active low; the chain returns to the initial values,
// the counts clear. The same happens after the fifth digest word is taken.
// A stalled receiver holds the current digest word; no input is taken until
// all five words have been accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  input  wire logic [0:0]  in_tuser,   // [0] end_only
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic             out_tlast,  // last_word
  output logic [2:0]       out_tuser   // [2:0] word_index
);

  sha1_pkg::cmd_t cmd;
  sha1_pkg::sts_t sts;

  sha1_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tlast    (in_tlast),
    .in_end_only (in_tuser[0]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .out_idx     (out_tuser),
    .sts         (sts),
    .cmd         (cmd)
  );

  sha1_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .sts         (sts),
    .digest_word (out_tdata)
  );

  // input and output phases never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  // a compression only starts on the byte that completes a block
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_work |-> (cmd.push && sts.fill == sha1_pkg::LAST_FILL))
    else $error("compression started on a partial block");

  // after the final digest word the engine is ready for a new message
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && sts.fill == 6'd0))
    else $error("engine not idle after digest");

endmodule

`default_nettype wire
